// ===== rtl/fin_pkg.sv =====
package fin_pkg;

  localparam int XW = 32;

  typedef enum logic [1:0] {
    METHOD_NONE   = 2'd0,
    METHOD_MINMAX = 2'd1,
    METHOD_MEANSD = 2'd2,
    METHOD_SPARE  = 2'd3
  } method_t;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SCALE = 1'b1;

  localparam logic CFG_METHOD = 1'b0;
  localparam logic CFG_RANGE  = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [5:0]        feature_index;
    logic signed [31:0] sample;
    logic signed [31:0] stat_minimum;
    logic signed [31:0] stat_maximum;
    logic signed [31:0] stat_mean;
    logic signed [31:0] stat_deviation;
  } in_item_t;

  typedef struct packed {
    logic [5:0]        result_index;
    logic signed [31:0] scaled_value;
    logic signed [31:0] slope;
    logic              bypassed;
    logic              below_minimum;
    logic              above_maximum;
  } out_item_t;

  // side information that rides along the divider pipeline
  typedef struct packed {
    logic       bypassed;
    logic       below_minimum;
    logic       above_maximum;
    logic       minmax;
    logic [5:0] index;
    logic signed [31:0] sample;
  } tag_t;

endpackage

// ===== rtl/fin_div.sv =====
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// Two dividends share the divisor: value numerator and slope numerator.
module fin_div #(
  parameter int NW = 66,
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num_a,
  input  logic [NW-1:0] in_num_b,
  input  logic [DW-1:0] in_den,
  input  logic          in_neg_a,
  input  fin_pkg::tag_t in_tag,
  output logic          out_valid,
  output logic [NW-1:0] out_quo_a,
  output logic [NW-1:0] out_quo_b,
  output logic          out_neg_a,
  output fin_pkg::tag_t out_tag
);
  logic          v   [NW+1];
  logic [NW-1:0] qa  [NW+1];
  logic [NW-1:0] qb  [NW+1];
  logic [DW:0]   ra  [NW+1];
  logic [DW:0]   rb  [NW+1];
  logic [DW-1:0] den [NW+1];
  logic          ng  [NW+1];
  fin_pkg::tag_t tg  [NW+1];

  assign v[0]   = in_valid;
  assign qa[0]  = in_num_a;
  assign qb[0]  = in_num_b;
  assign ra[0]  = '0;
  assign rb[0]  = '0;
  assign den[0] = in_den;
  assign ng[0]  = in_neg_a;
  assign tg[0]  = in_tag;

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW:0] ta, tb;
    logic        ka, kb;
    // shift in next dividend bit, trial subtract
    always_comb begin
      ta = {ra[s][DW-1:0], qa[s][NW-1]};
      tb = {rb[s][DW-1:0], qb[s][NW-1]};
      ka = ta >= {1'b0, den[s]};
      kb = tb >= {1'b0, den[s]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else begin
        v[s+1] <= v[s];
      end
      qa[s+1]  <= {qa[s][NW-2:0], ka};
      qb[s+1]  <= {qb[s][NW-2:0], kb};
      ra[s+1]  <= ka ? ta - {1'b0, den[s]} : ta;
      rb[s+1]  <= kb ? tb - {1'b0, den[s]} : tb;
      den[s+1] <= den[s];
      ng[s+1]  <= ng[s];
      tg[s+1]  <= tg[s];
    end
  end

  assign out_valid = v[NW];
  assign out_quo_a = qa[NW];
  assign out_quo_b = qb[NW];
  assign out_neg_a = ng[NW];
  assign out_tag   = tg[NW];
endmodule

// ===== rtl/feature_input_normalizer_top.sv =====
// Per-feature normalizer in signed fixed point. One item is taken every
// cycle (busy stays low). A scale item passes through the registered table
// read and difference stages, the bit-per-stage divider pipeline of
// 2*FRAC_BITS+34 stages and the finishing stage, and returns one result on
// done. Load items give no result. Results cannot be held off by the
// receiver. Scaling an entry never loaded gives an unspecified result.
module feature_input_normalizer_top #(
  parameter int FEATURES  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  fin_pkg::in_item_t in_item,
  output logic              done,
  output fin_pkg::out_item_t out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [1:0]        cfg_data
);
  localparam int AW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int NW = 2 * FRAC_BITS + 34;
  localparam int DW = 33;

  fin_pkg::method_t method;
  logic             range_en;
  logic [127:0]     mem [FEATURES];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      method   <= fin_pkg::METHOD_MINMAX;
      range_en <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fin_pkg::CFG_METHOD: method   <= fin_pkg::method_t'(cfg_data);
        fin_pkg::CFG_RANGE:  range_en <= cfg_data[0];
      endcase
    end
  end

  logic acc, in_range;
  assign acc      = start && !busy;
  assign in_range = ({26'd0, in_item.feature_index} < 32'(FEATURES));

  // table write on load, registered read on scale
  logic         s1_v, s1_zero;
  logic [127:0] s1_e;
  logic [5:0]   s1_idx;
  logic signed [31:0] s1_x;
  always_ff @(posedge clk) begin
    if (acc && in_item.opcode == fin_pkg::OP_LOAD && in_range) begin
      mem[AW'(in_item.feature_index)] <= {in_item.stat_minimum, in_item.stat_maximum,
                                          in_item.stat_mean, in_item.stat_deviation};
    end
    s1_e <= mem[AW'(in_item.feature_index)];
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= acc && in_item.opcode == fin_pkg::OP_SCALE;
    end
    s1_zero <= !in_range;
    s1_idx  <= in_item.feature_index;
    s1_x    <= in_item.sample;
  end

  // unpack entry, form differences and flags
  logic signed [31:0] e_min, e_max, e_mean, e_dev;
  assign e_min  = s1_zero ? '0 : s1_e[127:96];
  assign e_max  = s1_zero ? '0 : s1_e[95:64];
  assign e_mean = s1_zero ? '0 : s1_e[63:32];
  assign e_dev  = s1_zero ? '0 : s1_e[31:0];

  logic signed [32:0] s2_rng, s2_num;
  logic               s2_v, s2_mm, s2_ms;
  fin_pkg::tag_t      s2_tag;
  logic signed [32:0] rng_c, num_c;
  logic               mm_c, ms_c;
  always_comb begin
    rng_c = 33'(e_max) - 33'(e_min);
    mm_c  = (method == fin_pkg::METHOD_MINMAX) && !rng_c[32] && (rng_c != '0);
    ms_c  = (method == fin_pkg::METHOD_MEANSD) && !e_dev[31] && (e_dev != '0);
    num_c = mm_c ? 33'(s1_x) - 33'(e_min) : 33'(s1_x) - 33'(e_mean);
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
    s2_mm  <= mm_c;
    s2_ms  <= ms_c;
    s2_rng <= mm_c ? rng_c : 33'(e_dev);
    s2_num <= num_c;
    s2_tag.bypassed      <= !(mm_c || ms_c);
    s2_tag.below_minimum <= range_en && (s1_x < e_min);
    s2_tag.above_maximum <= range_en && (s1_x > e_max);
    s2_tag.minmax        <= mm_c;
    s2_tag.index         <= s1_idx;
    s2_tag.sample        <= s1_x;
  end

  // scale numerators to divider format
  logic [32:0]   mag;
  logic [NW-1:0] na, nb;
  always_comb begin
    mag = s2_num[32] ? 33'(-s2_num) : 33'(s2_num);
    na  = NW'({mag, {FRAC_BITS{1'b0}}}) << s2_mm;
    nb  = NW'(1) << (2 * FRAC_BITS + (s2_mm ? 1 : 0));
  end

  logic          d_v, d_neg;
  logic [NW-1:0] qa, qb;
  fin_pkg::tag_t d_tag;
  fin_div #(.NW(NW), .DW(DW)) u_div (
    .clk(clk), .rst(rst),
    .in_valid(s2_v), .in_num_a(na), .in_num_b(nb),
    .in_den((s2_mm || s2_ms) ? s2_rng : 33'd1), .in_neg_a(s2_num[32]),
    .in_tag(s2_tag),
    .out_valid(d_v), .out_quo_a(qa), .out_quo_b(qb), .out_neg_a(d_neg),
    .out_tag(d_tag)
  );

  // sign, offset, saturate
  localparam logic signed [NW+1:0] MAXV = (NW+2)'(32'sh7fffffff);
  localparam logic signed [NW+1:0] MINV = -(NW+2)'(33'sh080000000);
  logic signed [NW+1:0] sv, ss;
  logic signed [31:0]   ov, os;
  always_comb begin
    sv = d_neg ? -$signed({2'b00, qa}) : $signed({2'b00, qa});
    if (d_tag.minmax) sv = sv - ((NW+2)'(1) <<< FRAC_BITS);
    ss = $signed({2'b00, qb});
    ov = (sv > MAXV) ? 32'sh7fffffff : (sv < MINV) ? 32'sh80000000 : sv[31:0];
    os = (ss > MAXV) ? 32'sh7fffffff : ss[31:0];
    if (d_tag.bypassed) begin
      ov = d_tag.sample;
      os = 32'(1) <<< FRAC_BITS;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_v;
    end
    out_item.result_index  <= d_tag.index;
    out_item.scaled_value  <= ov;
    out_item.slope         <= os;
    out_item.bypassed      <= d_tag.bypassed;
    out_item.below_minimum <= d_tag.below_minimum;
    out_item.above_maximum <= d_tag.above_maximum;
  end

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && in_item.opcode == fin_pkg::OP_LOAD) |=> !s1_v) else $error("load made result");
  a_scale_tracks: assert property (@(posedge clk) disable iff (rst)
    s1_v |=> s2_v) else $error("stage lost item");
  a_bypass_slope: assert property (@(posedge clk) disable iff (rst)
    (done && out_item.bypassed) |-> (out_item.slope == (32'(1) <<< FRAC_BITS)))
    else $error("bypassed result without unit slope");
endmodule

// ===== sim/feature_input_normalizer_top_tb.sv =====
module feature_input_normalizer_top_tb;

  localparam int FRAC = 16;
  localparam int LATENCY = 2 * FRAC + 37;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 150;
  localparam int NUM_PHASES = 6;

  typedef struct {
    fin_pkg::in_item_t  item;
    bit                 has_exp;
    fin_pkg::out_item_t exp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  fin_pkg::in_item_t in_item = '0;
  logic done;
  fin_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = fin_pkg::CFG_METHOD;
  logic [1:0] cfg_data = '0;

  // shadow of the block's configuration and statistics table
  fin_pkg::method_t cur_method;
  bit cur_check;
  logic signed [31:0] tbl_min [64];
  logic signed [31:0] tbl_max [64];
  logic signed [31:0] tbl_mean [64];
  logic signed [31:0] tbl_dev [64];

  fin_pkg::out_item_t pending_results[$];
  stim_row_t directed_rows[$];
  int errors = 0;
  int n_loads = 0;
  int n_scales = 0;
  int n_checked = 0;
  int n_bypassed = 0;
  int idle_pct = 0;
  int stall_count = 0;

  feature_input_normalizer_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .done(done), .out_item(out_item), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // expected normalizer output for one scale item
  function automatic fin_pkg::out_item_t normalize(fin_pkg::in_item_t it);
    fin_pkg::out_item_t r;
    longint x, mn, mx, mu, sd, diff, val, slp, one;
    bit byp;
    x = it.sample;
    mn = tbl_min[it.feature_index];
    mx = tbl_max[it.feature_index];
    mu = tbl_mean[it.feature_index];
    sd = tbl_dev[it.feature_index];
    one = 64'sd1 <<< FRAC;
    val = x;
    slp = one;
    byp = 1'b1;
    diff = mx - mn;
    if (cur_method == fin_pkg::METHOD_MINMAX && diff > 0) begin
      val = ((x - mn) * 2 * one) / diff - one;
      slp = (64'sd1 <<< (2 * FRAC + 1)) / diff;
      byp = 1'b0;
    end else if (cur_method == fin_pkg::METHOD_MEANSD && sd > 0) begin
      val = ((x - mu) * one) / sd;
      slp = (64'sd1 <<< (2 * FRAC)) / sd;
      byp = 1'b0;
    end
    r.result_index = it.feature_index;
    r.scaled_value = sat32(val);
    r.slope = sat32(slp);
    r.bypassed = byp;
    r.below_minimum = cur_check && (x < mn);
    r.above_maximum = cur_check && (x > mx);
    return r;
  endfunction

  function automatic fin_pkg::in_item_t make_item(logic op, int idx, logic [31:0] x,
                                                  logic [31:0] mn, logic [31:0] mx,
                                                  logic [31:0] mu, logic [31:0] sd);
    fin_pkg::in_item_t it;
    it.opcode = op;
    it.feature_index = 6'(idx);
    it.sample = x;
    it.stat_minimum = mn;
    it.stat_maximum = mx;
    it.stat_mean = mu;
    it.stat_deviation = sd;
    return it;
  endfunction

  task automatic add_row(fin_pkg::in_item_t it, bit has_exp, fin_pkg::out_item_t exp);
    stim_row_t r;
    r.item = it;
    r.has_exp = has_exp;
    r.exp = exp;
    directed_rows.push_back(r);
  endtask

  task automatic report_mismatch(string field, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d", field, got, want);
    errors++;
  endtask

  // hold start until the transfer, then update the shadow table
  task automatic send_item(fin_pkg::in_item_t it, bit has_exp, fin_pkg::out_item_t exp);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    if (it.opcode == fin_pkg::OP_LOAD) begin
      tbl_min[it.feature_index] = it.stat_minimum;
      tbl_max[it.feature_index] = it.stat_maximum;
      tbl_mean[it.feature_index] = it.stat_mean;
      tbl_dev[it.feature_index] = it.stat_deviation;
      n_loads++;
    end else begin
      pending_results.push_back(has_exp ? exp : normalize(it));
      n_scales++;
    end
    // random sender gaps
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [1:0] val);
    drain_results();
    // loads leave nothing to wait for, so let the pipeline empty
    repeat (LATENCY + 10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == fin_pkg::CFG_METHOD) cur_method = fin_pkg::method_t'(val);
    else cur_check = val[0];
  endtask

  // statistics with a mix of wide, narrow and degenerate ranges
  function automatic fin_pkg::in_item_t random_load(int idx);
    logic [31:0] mn, mx, mu, sd;
    mn = $urandom;
    mx = $urandom;
    mu = $urandom;
    sd = $urandom;
    case ($urandom_range(5))
      0: mx = mn + $urandom_range(1, 16);
      1: mx = mn;
      2: sd = $urandom_range(1, 3);
      3: sd = -$signed({1'b0, 31'($urandom_range(0, 1000))});
      4: begin
        mn = -$signed({1'b0, 31'($urandom_range(1 << 24))});
        mx = $urandom_range(1 << 24);
        sd = $urandom_range(1, 1 << 22);
      end
      default: ;
    endcase
    return make_item(fin_pkg::OP_LOAD, idx, $urandom, mn, mx, mu, sd);
  endfunction

  function automatic fin_pkg::in_item_t random_scale();
    int idx;
    logic [31:0] x;
    idx = $urandom_range(63);
    case ($urandom_range(5))
      0: x = tbl_min[idx];
      1: x = tbl_max[idx];
      2: x = tbl_min[idx] - 1;
      3: x = tbl_max[idx] + 1;
      4: x = tbl_mean[idx] + $signed(32'($urandom_range(0, 1 << 20))) - (1 << 19);
      default: x = $urandom;
    endcase
    return make_item(fin_pkg::OP_SCALE, idx, x, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    fin_pkg::out_item_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result_index", out_item.result_index, -1);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (want.bypassed) n_bypassed++;
        if (out_item.result_index !== want.result_index)
          report_mismatch("result_index", out_item.result_index, want.result_index);
        if (out_item.scaled_value !== want.scaled_value)
          report_mismatch("scaled_value", out_item.scaled_value, want.scaled_value);
        if (out_item.slope !== want.slope)
          report_mismatch("slope", out_item.slope, want.slope);
        if (out_item.bypassed !== want.bypassed)
          report_mismatch("bypassed", out_item.bypassed, want.bypassed);
        if (out_item.below_minimum !== want.below_minimum)
          report_mismatch("below_minimum", out_item.below_minimum, want.below_minimum);
        if (out_item.above_maximum !== want.above_maximum)
          report_mismatch("above_maximum", out_item.above_maximum, want.above_maximum);
      end
    end
  end

  // abort when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("feature_input_normalizer_top_tb failed");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    fin_pkg::out_item_t none;
    logic [1:0] phase_method [NUM_PHASES];
    bit phase_check [NUM_PHASES];
    int phase_idle [NUM_PHASES];
    none = '0;
    phase_method = '{fin_pkg::METHOD_MEANSD, fin_pkg::METHOD_NONE, fin_pkg::METHOD_MINMAX,
                     fin_pkg::METHOD_SPARE, fin_pkg::METHOD_MEANSD, fin_pkg::METHOD_MINMAX};
    phase_check = '{1, 0, 1, 1, 0, 0};
    phase_idle = '{0, 45, 13, 0, 45, 13};
    cur_method = fin_pkg::METHOD_MINMAX;
    cur_check = 1'b1;

    // unit range at entry zero
    add_row(make_item(fin_pkg::OP_LOAD, 0, 0, 0, 65536, 0, 65536), 0, none);
    add_row(make_item(fin_pkg::OP_SCALE, 0, 0, 0, 0, 0, 0), 1,
            '{0, -65536, 131072, 0, 0, 0});
    add_row(make_item(fin_pkg::OP_SCALE, 0, 65536, 0, 0, 0, 0), 1,
            '{0, 65536, 131072, 0, 0, 0});
    add_row(make_item(fin_pkg::OP_SCALE, 0, 32768, 0, 0, 0, 0), 1,
            '{0, 0, 131072, 0, 0, 0});
    add_row(make_item(fin_pkg::OP_SCALE, 0, -65536, 0, 0, 0, 0), 1,
            '{0, -196608, 131072, 0, 1, 0});
    // zero range passes the sample through
    add_row(make_item(fin_pkg::OP_LOAD, 63, 0, 5, 5, 5, 0), 0, none);
    add_row(make_item(fin_pkg::OP_SCALE, 63, 7, 0, 0, 0, 0), 1, '{63, 7, 65536, 1, 0, 1});
    // full-scale range and extreme samples
    add_row(make_item(fin_pkg::OP_LOAD, 1, 0, 32'h80000000, 32'h7fffffff, 0, 32'h7fffffff),
            0, none);
    add_row(make_item(fin_pkg::OP_SCALE, 1, 32'h7fffffff, 0, 0, 0, 0), 0, none);
    add_row(make_item(fin_pkg::OP_SCALE, 1, 32'h80000000, 0, 0, 0, 0), 0, none);
    // tiny range saturates value and slope
    add_row(make_item(fin_pkg::OP_LOAD, 2, 0, 0, 1, 0, 1), 0, none);
    add_row(make_item(fin_pkg::OP_SCALE, 2, 32'h7fffffff, 0, 0, 0, 0), 1,
            '{2, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 1});
    add_row(make_item(fin_pkg::OP_SCALE, 2, 32'h80000000, 0, 0, 0, 0), 1,
            '{2, 32'sh80000000, 32'sh7fffffff, 0, 1, 0});
    // inverted range is degenerate, both flags raised
    add_row(make_item(fin_pkg::OP_LOAD, 3, 0, 10, -10, 0, -1), 0, none);
    add_row(make_item(fin_pkg::OP_SCALE, 3, 0, 0, 0, 0, 0), 1, '{3, 0, 65536, 1, 1, 1});

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) send_item(directed_rows[i].item, directed_rows[i].has_exp,
                                         directed_rows[i].exp);

    // fill every entry before any random scale
    for (int i = 0; i < 64; i++) send_item(random_load(i), 0, none);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(fin_pkg::CFG_METHOD, phase_method[p]);
      write_reg(fin_pkg::CFG_RANGE, {1'b0, phase_check[p]});
      idle_pct = phase_idle[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == PHASE_ITEMS / 2) drain_results();
        if ($urandom_range(99) < 20) send_item(random_load($urandom_range(63)), 0, none);
        else send_item(random_scale(), 0, none);
      end
    end

    drain_results();
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d loads and %0d scales over %0d setting phases", n_loads, n_scales,
             NUM_PHASES);
    $display("checked %0d results, %0d passed through unscaled", n_checked, n_bypassed);
    if (errors == 0) begin
      $display("feature_input_normalizer_top_tb passed");
    end else begin
      $display("feature_input_normalizer_top_tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fin_pkg.sv
rtl/fin_div.sv
rtl/feature_input_normalizer_top.sv
sim/feature_input_normalizer_top_tb.sv
